// ===== sv/mkd_pkg.sv =====
// Shared types and constants for the Morse key decoder.
// No dependencies; morse_key_decoder and mkd_decode refer to this package by scoped names.
`default_nettype none

package mkd_pkg;

  // Event kinds carried on the result channel.
  localparam logic [2:0] EV_DOT     = 3'd0;
  localparam logic [2:0] EV_DASH    = 3'd1;
  localparam logic [2:0] EV_CHAR    = 3'd2;
  localparam logic [2:0] EV_INVALID = 3'd3;
  localparam logic [2:0] EV_WORD    = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DOT_MIN  = 2'd0;
  localparam logic [1:0] CFG_DASH_MIN = 2'd1;
  localparam logic [1:0] CFG_GAP      = 2'd2;

  localparam int CFG_BITS = 16;

  localparam logic [CFG_BITS-1:0] DOT_MIN_RESET  = 16'd1874;
  localparam logic [CFG_BITS-1:0] DASH_MIN_RESET = 16'd12499;
  localparam logic [CFG_BITS-1:0] GAP_RESET      = 16'd24999;

  // Pattern holds only the sentinel bit.
  localparam logic [7:0] PATTERN_EMPTY = 8'h01;

  localparam logic [6:0] ASCII_SPACE = 7'd32;

  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] code;
  } event_t;

endpackage

`default_nettype wire

// ===== sv/mkd_key_if.sv =====
// Input channel of the Morse key decoder: one sampled key level per word.
// Depends on nothing.
`default_nettype none

interface mkd_key_if;
  logic valid;
  logic ready;
  logic key_level;

  modport source (output valid, output key_level, input ready);
  modport sink (input valid, input key_level, output ready);
endinterface

`default_nettype wire

// ===== sv/mkd_event_if.sv =====
// Result channel of the Morse key decoder: one decoded event per word.
// Depends on nothing.
`default_nettype none

interface mkd_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [6:0] char_code;

  modport source (output valid, output event_kind, output char_code, input ready);
  modport sink (input valid, input event_kind, input char_code, output ready);
endinterface

`default_nettype wire

// ===== sv/morse_key_decoder.sv =====
// Morse key decoder top level: timing of key presses, mark classification, letter decode.
// A key word passes through the input register, and its event, if any, is then registered in the
// output register; throughput is one key word per cycle, limited only by the result register.
// Reset clears the timing state, empties the pattern and reloads the default thresholds.
// Depends on mkd_pkg, mkd_key_if, mkd_event_if and mkd_decode.
`default_nettype none

module morse_key_decoder #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [mkd_pkg::CFG_BITS-1:0]  cfg_data,
  mkd_key_if.sink                            key,
  mkd_event_if.source                        symbol
);

  // Configuration.
  logic [mkd_pkg::CFG_BITS-1:0] dot_min_ticks;
  logic [mkd_pkg::CFG_BITS-1:0] dash_min_ticks;
  logic [mkd_pkg::CFG_BITS-1:0] gap_period_ticks;

  // Input register.
  logic in_valid;
  logic in_level;

  // Decoder state.
  logic                  last_level;
  logic [COUNT_BITS-1:0] tick_count;
  logic                  compare_enabled;
  logic                  long_press;
  logic [7:0]            pattern;
  logic [1:0]            empty_gap_count;

  logic                  last_level_next;
  logic [COUNT_BITS-1:0] tick_count_next;
  logic                  compare_enabled_next;
  logic                  long_press_next;
  logic [7:0]            pattern_next;
  logic [1:0]            empty_gap_count_next;

  // Output register.
  logic            out_valid;
  mkd_pkg::event_t out_word;

  mkd_pkg::event_t step_word;
  logic            step_emit;
  mkd_pkg::event_t lookup;

  logic change;
  logic gap_match;
  logic advance;

  mkd_decode u_decode (
    .pattern (pattern),
    .result  (lookup)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_min_ticks    <= mkd_pkg::DOT_MIN_RESET;
      dash_min_ticks   <= mkd_pkg::DASH_MIN_RESET;
      gap_period_ticks <= mkd_pkg::GAP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        mkd_pkg::CFG_DOT_MIN:  dot_min_ticks    <= cfg_data;
        mkd_pkg::CFG_DASH_MIN: dash_min_ticks   <= cfg_data;
        mkd_pkg::CFG_GAP:      gap_period_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  assign change    = in_level != last_level;
  assign gap_match = tick_count >= COUNT_BITS'(gap_period_ticks);

  always_comb begin
    last_level_next      = last_level;
    tick_count_next      = tick_count + COUNT_BITS'(1);
    compare_enabled_next = compare_enabled;
    long_press_next      = long_press;
    pattern_next         = pattern;
    empty_gap_count_next = empty_gap_count;
    step_emit            = 1'b0;
    step_word.kind       = mkd_pkg::EV_DOT;
    step_word.code       = 7'd0;

    if (change) begin
      // A release ends a press: classify its length.
      if (last_level) begin
        if (tick_count >= COUNT_BITS'(dash_min_ticks) || long_press) begin
          pattern_next   = {pattern[6:0], 1'b1};
          step_emit      = 1'b1;
          step_word.kind = mkd_pkg::EV_DASH;
        end else if (tick_count >= COUNT_BITS'(dot_min_ticks)) begin
          pattern_next   = {pattern[6:0], 1'b0};
          step_emit      = 1'b1;
          step_word.kind = mkd_pkg::EV_DOT;
        end
      end
      tick_count_next      = '0;
      long_press_next      = 1'b0;
      compare_enabled_next = 1'b1;
      last_level_next      = in_level;
    end else if (gap_match) begin
      tick_count_next = '0;
      if (compare_enabled) begin
        if (last_level) begin
          long_press_next      = 1'b1;
          compare_enabled_next = 1'b0;
        end else begin
          pattern_next = mkd_pkg::PATTERN_EMPTY;
          if (pattern == mkd_pkg::PATTERN_EMPTY) begin
            // Only the first empty gap after a character gives a word space.
            if (empty_gap_count != 2'd2) begin
              empty_gap_count_next = empty_gap_count + 2'd1;
            end
            if (empty_gap_count == 2'd0) begin
              step_emit      = 1'b1;
              step_word.kind = mkd_pkg::EV_WORD;
              step_word.code = mkd_pkg::ASCII_SPACE;
            end
          end else begin
            empty_gap_count_next = 2'd0;
            step_emit            = 1'b1;
            step_word            = lookup;
          end
        end
      end
    end
  end

  // Words with no event pass through even while the result register is full.
  assign advance   = in_valid && (!step_emit || !out_valid || symbol.ready);
  assign key.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (key.ready) begin
      in_valid <= key.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (key.ready && key.valid) begin
      in_level <= key.key_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level      <= 1'b0;
      tick_count      <= '0;
      compare_enabled <= 1'b0;
      long_press      <= 1'b0;
      pattern         <= mkd_pkg::PATTERN_EMPTY;
      empty_gap_count <= 2'd0;
    end else if (advance) begin
      last_level      <= last_level_next;
      tick_count      <= tick_count_next;
      compare_enabled <= compare_enabled_next;
      long_press      <= long_press_next;
      pattern         <= pattern_next;
      empty_gap_count <= empty_gap_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && step_emit) begin
      out_valid <= 1'b1;
    end else if (symbol.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_emit) begin
      out_word <= step_word;
    end
  end

  assign symbol.valid      = out_valid;
  assign symbol.event_kind = out_word.kind;
  assign symbol.char_code  = out_word.code;

  // A long press always disables the gap compare until the next level change.
  assert property (@(posedge clk) disable iff (rst) long_press |-> !compare_enabled)
    else $error("long press seen while gap compare enabled");

  assert property (@(posedge clk) disable iff (rst) empty_gap_count != 2'd3)
    else $error("empty gap count passed its saturation value");

  assert property (@(posedge clk) disable iff (rst) advance && step_emit |=> out_valid)
    else $error("event produced but result register empty");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_word.kind == mkd_pkg::EV_DOT || out_word.kind == mkd_pkg::EV_DASH ||
                  out_word.kind == mkd_pkg::EV_INVALID) |-> out_word.code == 7'd0)
    else $error("mark or invalid event carries a character code");

endmodule

`default_nettype wire

// ===== sv/mkd_decode.sv =====
// Pattern lookup: maps a sentinel-prefixed mark pattern to a letter or digit.
// Depends on mkd_pkg for the event kinds and the event_t struct.
`default_nettype none

module mkd_decode (
  input  wire logic [7:0]     pattern,
  output mkd_pkg::event_t     result
);

  logic [6:0] ascii;
  logic       found;

  // A one marks a dash, a zero a dot; the leading one is the sentinel.
  always_comb begin
    found = 1'b1;
    unique case (pattern)
      8'h05: ascii = 7'h41;
      8'h18: ascii = 7'h42;
      8'h1A: ascii = 7'h43;
      8'h0C: ascii = 7'h44;
      8'h02: ascii = 7'h45;
      8'h12: ascii = 7'h46;
      8'h0E: ascii = 7'h47;
      8'h10: ascii = 7'h48;
      8'h04: ascii = 7'h49;
      8'h17: ascii = 7'h4A;
      8'h0D: ascii = 7'h4B;
      8'h14: ascii = 7'h4C;
      8'h07: ascii = 7'h4D;
      8'h06: ascii = 7'h4E;
      8'h0F: ascii = 7'h4F;
      8'h16: ascii = 7'h50;
      8'h1D: ascii = 7'h51;
      8'h0A: ascii = 7'h52;
      8'h08: ascii = 7'h53;
      8'h03: ascii = 7'h54;
      8'h09: ascii = 7'h55;
      8'h11: ascii = 7'h56;
      8'h0B: ascii = 7'h57;
      8'h19: ascii = 7'h58;
      8'h1B: ascii = 7'h59;
      8'h1C: ascii = 7'h5A;
      8'h2F: ascii = 7'h31;
      8'h27: ascii = 7'h32;
      8'h23: ascii = 7'h33;
      8'h21: ascii = 7'h34;
      8'h20: ascii = 7'h35;
      8'h30: ascii = 7'h36;
      8'h38: ascii = 7'h37;
      8'h3C: ascii = 7'h38;
      8'h3E: ascii = 7'h39;
      8'h3F: ascii = 7'h30;
      default: begin
        ascii = 7'd0;
        found = 1'b0;
      end
    endcase
  end

  assign result.kind = found ? mkd_pkg::EV_CHAR : mkd_pkg::EV_INVALID;
  assign result.code = ascii;

endmodule

`default_nettype wire
